### rtl/dtaf_pkg.sv
package dtaf_pkg;

	localparam int VALUE_W        = 128;
	localparam int HALF_W         = 64;
	localparam int CNT_W          = $clog2(VALUE_W);
	localparam int SCALE_W        = 6;
	localparam int SCALE_LIMIT    = 38;
	localparam int DTAF_MAX_DIGITS = 39;
	localparam int CHAR_W         = 8;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'd46;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_INTD,
		ST_POINT,
		ST_FRAC,
		ST_ZERO
	} dtaf_state_t;

endpackage

### rtl/decimal_to_ascii_formatter_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: value_high [63:0], value_low [127:64]
// m_*       out  m_tvalid/m_tready  m_tdata: text_char [7:0]; m_tlast: last_char
// cfg_*     in   cfg_valid/cfg_ready cfg_data: scale [5:0]
//
// An item is loaded, then converted by bit-serial double dabble
// (one magnitude bit per cycle), then leading zero digits are stepped
// over, then its characters are emitted while the output is taken.
// The next item is accepted once the last character sits in the output register.
// arst_n clears control state and the scale register; data registers are not reset.
// A stall on m_tready holds the character and pauses the digit sequencer.
module decimal_to_ascii_formatter_top
	import dtaf_pkg::*;
#(
	parameter int MAX_DIGITS = DTAF_MAX_DIGITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [VALUE_W-1:0]   s_tdata,   // value_high [63:0], value_low [127:64]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CHAR_W-1:0]    m_tdata,   // text_char [7:0]
	output logic                 m_tlast,   // last_char
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SCALE_W-1:0]   cfg_data   // scale [5:0]
);

	localparam int BCD_W = 4 * MAX_DIGITS;

	dtaf_state_t state_q, state_d;

	logic [SCALE_W-1:0] scale_q;
	logic [SCALE_W-1:0] sc_q;
	logic [SCALE_W-1:0] pos_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] mag_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   dd_adj;
	logic               neg_q;
	logic               zero_q;

	logic               m_tvalid_q;
	logic [CHAR_W-1:0]  m_tdata_q;
	logic               m_tlast_q;

	logic [VALUE_W-1:0] in_value;
	logic               s_xfer;
	logic               can_emit;
	logic               emit;
	logic               consume;
	logic [CHAR_W-1:0]  emit_char;
	logic               emit_last;
	logic [3:0]         dig;
	logic               dig_live;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign in_value  = {s_tdata[HALF_W-1:0], s_tdata[VALUE_W-1:HALF_W]};
	assign can_emit  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Position counter runs from SCALE_LIMIT down; the BCD top digit is position
	// MAX_DIGITS-1, and only shifts once pos_q reaches it.
	assign dig_live = (pos_q < SCALE_W'(MAX_DIGITS));
	assign dig      = dig_live ? bcd_q[BCD_W-1 -: 4] : 4'd0;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                             : bcd_q[i*4 +: 4];
		end
	end

	// Output decode
	always_comb begin
		emit      = 1'b0;
		consume   = 1'b0;
		emit_char = CHAR_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE, ST_CONV: begin
			end
			ST_SIGN: begin
				emit      = can_emit;
				emit_char = CHAR_MINUS;
			end
			ST_SKIP: begin
				consume = (dig == 4'd0) && (pos_q != sc_q);
			end
			ST_INTD, ST_FRAC: begin
				emit      = can_emit;
				consume   = can_emit;
				emit_char = CHAR_ZERO + {4'd0, dig};
				emit_last = (pos_q == '0);
			end
			ST_POINT: begin
				emit      = can_emit;
				emit_char = CHAR_DOT;
			end
			ST_ZERO: begin
				emit      = can_emit;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_xfer) state_d = ST_CONV;
			ST_CONV: begin
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					if (zero_q)     state_d = ST_ZERO;
					else if (neg_q) state_d = ST_SIGN;
					else            state_d = ST_SKIP;
				end
			end
			ST_SIGN:  if (can_emit) state_d = ST_SKIP;
			ST_SKIP:  if (dig != 4'd0 || pos_q == sc_q) state_d = ST_INTD;
			ST_INTD: begin
				if (can_emit && pos_q == sc_q)
					state_d = (sc_q != '0) ? ST_POINT : ST_IDLE;
			end
			ST_POINT: if (can_emit) state_d = ST_FRAC;
			ST_FRAC:  if (can_emit && pos_q == '0) state_d = ST_IDLE;
			ST_ZERO:  if (can_emit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scale_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				scale_q <= cfg_data;
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= emit_char;
			m_tlast_q <= emit_last;
		end
		if (s_xfer) begin
			neg_q  <= in_value[VALUE_W-1];
			zero_q <= (in_value == '0);
			mag_q  <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
			bcd_q  <= '0;
			cnt_q  <= '0;
			sc_q   <= (scale_q > SCALE_W'(SCALE_LIMIT)) ? SCALE_W'(SCALE_LIMIT) : scale_q;
			pos_q  <= SCALE_W'(SCALE_LIMIT);
		end else if (state_q == ST_CONV) begin
			bcd_q <= {dd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (consume) begin
			if (dig_live)
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			pos_q <= pos_q - SCALE_W'(1);
		end
	end

endmodule

### rtl/dtaf_checker.sv
module dtaf_checker
	import dtaf_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [VALUE_W-1:0]  s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [CHAR_W-1:0]   m_tdata,
	input logic                m_tlast,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [SCALE_W-1:0]  cfg_data
);

	// held character must not change under backpressure
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == CHAR_MINUS || m_tdata == CHAR_DOT ||
		              (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)))
		else $error("illegal character");

	a_no_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CHAR_MINUS || m_tdata == CHAR_DOT) |-> !m_tlast)
		else $error("sign or point flagged as last");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken during conversion");

	a_cfg_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind decimal_to_ascii_formatter_top dtaf_checker u_dtaf_checker (.*);
